@@ src/sbps_pkg.sv @@
// Shared constants for the shortest bitwise program search unit.
// Op codes, variable patterns, default sizes and field widths.
// No dependencies.
`default_nettype none
package sbps_pkg;
  localparam int unsigned MaxLenDef   = 15;
  localparam int unsigned MaxStackDef = 4;

  localparam int unsigned LvlW   = 4;
  localparam int unsigned OpW    = 4;
  localparam int unsigned ProgW  = 60;
  localparam int unsigned EntryW = 64;
  localparam int unsigned TtW    = 16;
  localparam int unsigned FillW  = 17;

  localparam logic [OpW-1:0] OP_PUSH1 = 4'd1;
  localparam logic [OpW-1:0] OP_PUSH4 = 4'd4;
  localparam logic [OpW-1:0] OP_AND   = 4'd5;
  localparam logic [OpW-1:0] OP_OR    = 4'd6;
  localparam logic [OpW-1:0] OP_XOR   = 4'd7;
  localparam logic [OpW-1:0] OP_NOT   = 4'd8;

  localparam logic CMD_RUN  = 1'b0;
  localparam logic CMD_READ = 1'b1;

  function automatic logic [TtW-1:0] var_pattern(input logic [OpW-1:0] op);
    logic [1:0] sel;
    sel = 2'(op - OP_PUSH1);
    case (sel)
      2'd0:    var_pattern = 16'hAAAA;
      2'd1:    var_pattern = 16'hCCCC;
      2'd2:    var_pattern = 16'hF0F0;
      default: var_pattern = 16'hFF00;
    endcase
  endfunction
endpackage
`default_nettype wire

@@ src/sbps_ram.sv @@
// Generic single-port-write, single-port-read RAM with registered read.
// Holds the table of best programs. No dependencies.
`default_nettype none
module sbps_ram #(
  parameter int unsigned Width = 64,
  parameter int unsigned Depth = 65536
) (
  input  wire logic                     clk_i,
  input  wire logic                     we_i,
  input  wire logic [$clog2(Depth)-1:0] waddr_i,
  input  wire logic [Width-1:0]         wdata_i,
  input  wire logic [$clog2(Depth)-1:0] raddr_i,
  output logic      [Width-1:0]         rdata_o
);
  logic [Width-1:0] mem_q [Depth];

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end
endmodule
`default_nettype wire

@@ src/shortest_bitwise_program_search_unit.sv @@
// Top level of the shortest bitwise program search unit.
// Uses sbps_pkg for constants and sbps_ram for the 64K-entry program table.
`default_nettype none
// The unit takes a command when start is high and busy is low. A read command
// (opcode 1) works thus: the accepting cycle presents truth_table to the
// table RAM, and the next cycle, with busy high, drives the entry as the result
// transfer. A run command (opcode 0) first sweeps the table to zero, one entry
// a cycle, then walks the depth-first enumeration one candidate op per cycle,
// apart from the steps that pop back or check the table. The walk tries all
// eight candidate ops of every search node whose children are tried, the empty
// start frame included, and then pops back. Each candidate that survives
// pruning and leaves a single value passes through a check state that reads
// the looked-up entry and maybe updates the table. The run ends with its result
// transfer; with max_ops at 0 or 1 the walk tries no candidates. After reset
// the same clearing sweep runs once with busy high. Each result sits on the
// ports for exactly one cycle with result_valid_o high; the receiver cannot
// hold it off, so capture it there. Write max_ops only while idle.
module shortest_bitwise_program_search_unit #(
  parameter int unsigned MAX_LEN   = sbps_pkg::MaxLenDef,
  parameter int unsigned MAX_STACK = sbps_pkg::MaxStackDef
) (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        opcode_i,
  input  wire logic [15:0] truth_table_i,
  output logic             result_valid_o,
  output logic [3:0]       entry_length_o,
  output logic [59:0]      entry_program_o,
  output logic [16:0]      filled_count_o,
  input  wire logic        psel,
  input  wire logic        penable,
  input  wire logic        pwrite,
  input  wire logic [2:0]  paddr,
  input  wire logic [31:0] pwdata,
  output logic [31:0]      prdata,
  output logic             pready
);
  localparam int unsigned LvlW   = sbps_pkg::LvlW;
  localparam int unsigned OpW    = sbps_pkg::OpW;
  localparam int unsigned TtW    = sbps_pkg::TtW;
  localparam int unsigned CntW   = $clog2(MAX_STACK + 1);
  localparam int unsigned SiW    = $clog2(MAX_STACK);
  localparam int unsigned LiW    = (MAX_LEN > 1) ? $clog2(MAX_LEN) : 1;
  localparam int unsigned OpsW   = OpW * (MAX_LEN + 1);

  localparam logic [2:0] S_CLEAR    = 3'd0;
  localparam logic [2:0] S_IDLE     = 3'd1;
  localparam logic [2:0] S_RD_OUT   = 3'd2;
  localparam logic [2:0] S_STEP     = 3'd3;
  localparam logic [2:0] S_CHECK    = 3'd4;
  localparam logic [2:0] S_RUN_DONE = 3'd5;

  logic [2:0] state_q, state_d;

  // Configuration: one register, max_ops, at byte address 0.
  logic [3:0] max_ops_q;
  logic       cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel & penable & pwrite & (paddr[2] == 1'b0);
  assign prdata = (paddr[2] == 1'b0) ? {28'd0, max_ops_q} : 32'd0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_ops_q <= 4'd15;
    end else if (cfg_wr) begin
      max_ops_q <= pwdata[3:0];
    end
  end

  logic [LvlW-1:0] levels;
  always_comb begin
    if (max_ops_q == '0) begin
      levels = LvlW'(1);
    end else if (max_ops_q > LvlW'(MAX_LEN)) begin
      levels = LvlW'(MAX_LEN);
    end else begin
      levels = max_ops_q;
    end
  end

  // Search frame: op and depth per level packed, stack per level.
  logic [OpsW-1:0]          ops_q;
  logic [CntW*MAX_LEN-1:0]  cnt_q;
  logic [TtW-1:0]           vals_q [MAX_LEN][MAX_STACK];
  logic [LvlW-1:0]          lvl_q, lvl_d;
  logic                     descend_q, descend_d;
  logic [TtW-1:0]           t_q;
  logic [15:0]              clr_q;
  logic                     run_q;
  logic [16:0]              filled_q;

  // Table RAM port signals.
  logic                     ram_we;
  logic [15:0]              ram_waddr, ram_raddr;
  logic [63:0]              ram_wdata, ram_rdata;

  sbps_ram #(
    .Width(sbps_pkg::EntryW),
    .Depth(65536)
  ) u_table (
    .clk_i  (clk_i),
    .we_i   (ram_we),
    .waddr_i(ram_waddr),
    .wdata_i(ram_wdata),
    .raddr_i(ram_raddr),
    .rdata_o(ram_rdata)
  );

  // Candidate evaluation for the STEP state.
  logic            eval;
  logic [LvlW-1:0] nl;
  logic [OpW-1:0]  nop, prev_op, pp_op, cur_op;
  logic [CntW-1:0] s, ns;
  logic [LvlW-1:0] remaining;
  logic            prune;
  logic [TtW-1:0]  dst [MAX_STACK];
  logic [LiW-1:0]  nl_i, src_i;
  logic [SiW-1:0]  s_i, s_m1, s_m2;

  always_comb begin
    nl_i    = nl[LiW-1:0];
    src_i   = LiW'(nl - LvlW'(1));
    prev_op = ops_q[OpW*(nl - LvlW'(1)) +: OpW];
    pp_op   = (nl >= LvlW'(2)) ? ops_q[OpW*(nl - LvlW'(2)) +: OpW] : '0;
    s       = cnt_q[CntW*(nl - LvlW'(1)) +: CntW];
    s_i     = s[SiW-1:0];
    s_m1    = s_i - SiW'(1);
    s_m2    = s_i - SiW'(2);

    if (nop <= sbps_pkg::OP_PUSH4) begin
      ns = s + CntW'(1);
    end else if (nop == sbps_pkg::OP_NOT) begin
      ns = s;
    end else begin
      ns = s - CntW'(1);
    end
    remaining = levels - LvlW'(1) - nl;

    prune = 1'b0;
    if (s >= CntW'(MAX_STACK)) prune = 1'b1;
    if (nl >= LvlW'(2) && pp_op >= sbps_pkg::OP_PUSH1 && prev_op <= sbps_pkg::OP_PUSH4) begin
      if ((nop == sbps_pkg::OP_AND || nop == sbps_pkg::OP_OR) && pp_op >= prev_op) prune = 1'b1;
      if (nop == sbps_pkg::OP_XOR && pp_op > prev_op) prune = 1'b1;
    end
    if ((nop == sbps_pkg::OP_AND || nop == sbps_pkg::OP_OR || nop == sbps_pkg::OP_XOR)
        && s < CntW'(2)) prune = 1'b1;
    if (nop == sbps_pkg::OP_NOT && s == '0) prune = 1'b1;
    if (ns == '0) prune = 1'b1;
    if ((5'(ns) > 5'(remaining) + 5'd1)) prune = 1'b1;
    if (prev_op == sbps_pkg::OP_NOT && nop == sbps_pkg::OP_NOT) prune = 1'b1;

    for (int i = 0; i < MAX_STACK; i++) begin
      dst[i] = vals_q[src_i][i];
    end
    if (nop <= sbps_pkg::OP_PUSH4) begin
      dst[s_i] = sbps_pkg::var_pattern(nop);
    end else if (nop == sbps_pkg::OP_NOT) begin
      dst[s_m1] = ~dst[s_m1];
    end else if (nop == sbps_pkg::OP_AND) begin
      dst[s_m2] = dst[s_m2] & dst[s_m1];
    end else if (nop == sbps_pkg::OP_OR) begin
      dst[s_m2] = dst[s_m2] | dst[s_m1];
    end else begin
      dst[s_m2] = dst[s_m2] ^ dst[s_m1];
    end
  end

  // Program of the current path, levels 1..lvl.
  logic [59:0] prog;
  always_comb begin
    prog = '0;
    for (int i = 1; i <= MAX_LEN; i++) begin
      if (LvlW'(i) <= lvl_q) begin
        prog[OpW*(i-1) +: OpW] = ops_q[OpW*i +: OpW];
      end
    end
  end

  logic [3:0] elen;
  logic       known;
  assign elen  = ram_rdata[63:60];
  assign known = (elen != '0) && (elen <= lvl_q);

  // Sequencer.
  always_comb begin
    state_d   = state_q;
    lvl_d     = lvl_q;
    descend_d = descend_q;
    eval      = 1'b0;
    nl        = lvl_q;
    cur_op    = ops_q[OpW*lvl_q +: OpW];
    nop       = cur_op + OpW'(1);
    ram_we    = 1'b0;
    ram_waddr = t_q;
    ram_wdata = {lvl_q, prog};
    ram_raddr = truth_table_i;

    case (state_q)
      S_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_q;
        ram_wdata = '0;
        if (clr_q == 16'hFFFF) begin
          state_d   = run_q ? S_STEP : S_IDLE;
          lvl_d     = '0;
          descend_d = 1'b1;
        end
      end
      S_IDLE: begin
        if (start) begin
          state_d = (opcode_i == sbps_pkg::CMD_RUN) ? S_CLEAR : S_RD_OUT;
        end
      end
      S_RD_OUT: begin
        state_d = S_IDLE;
      end
      S_STEP: begin
        if (descend_q && (lvl_q + LvlW'(1) < levels)) begin
          nl   = lvl_q + LvlW'(1);
          nop  = sbps_pkg::OP_PUSH1;
          eval = 1'b1;
        end else if (lvl_q == '0) begin
          state_d = S_RUN_DONE;
        end else if (nop > sbps_pkg::OP_NOT) begin
          lvl_d     = lvl_q - LvlW'(1);
          descend_d = 1'b0;
          if (lvl_q == LvlW'(1)) begin
            state_d = S_RUN_DONE;
            lvl_d   = '0;
          end
        end else begin
          eval = 1'b1;
        end
        if (eval) begin
          lvl_d     = nl;
          descend_d = 1'b0;
          ram_raddr = dst[0];
          if (!prune) begin
            if (ns == CntW'(1)) begin
              state_d = S_CHECK;
            end else begin
              descend_d = 1'b1;
            end
          end
        end
      end
      S_CHECK: begin
        state_d = S_STEP;
        if (!known) begin
          ram_we    = 1'b1;
          descend_d = 1'b1;
        end
      end
      S_RUN_DONE: begin
        state_d = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      lvl_q     <= '0;
      descend_q <= 1'b0;
      clr_q     <= '0;
      run_q     <= 1'b0;
      filled_q  <= '0;
      ops_q     <= '0;
      cnt_q     <= '0;
    end else begin
      state_q   <= state_d;
      lvl_q     <= lvl_d;
      descend_q <= descend_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 16'd1;
      end
      if (state_q == S_IDLE && start && opcode_i == sbps_pkg::CMD_RUN) begin
        clr_q    <= '0;
        run_q    <= 1'b1;
        filled_q <= '0;
      end
      if (state_q == S_RUN_DONE) begin
        run_q <= 1'b0;
      end
      if (eval) begin
        ops_q[OpW*nl +: OpW] <= nop;
        if (!prune) begin
          cnt_q[CntW*nl +: CntW] <= ns;
        end
      end
      if (state_q == S_CHECK && elen == '0) begin
        filled_q <= filled_q + 17'd1;
      end
    end
  end

  // Stack and table address of the candidate: payload, no reset.
  always_ff @(posedge clk_i) begin
    if (eval && !prune) begin
      for (int i = 0; i < MAX_STACK; i++) begin
        vals_q[nl_i][i] <= dst[i];
      end
      t_q <= dst[0];
    end
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = (state_q == S_RD_OUT) || (state_q == S_RUN_DONE);
  assign entry_length_o  = (state_q == S_RD_OUT) ? ram_rdata[63:60] : '0;
  assign entry_program_o = (state_q == S_RD_OUT) ? ram_rdata[59:0] : '0;
  assign filled_count_o  = filled_q;
endmodule
`default_nettype wire

@@ sim/tb.sv @@
// Testbench for the shortest bitwise program search unit.
// Drives run and read commands, rewrites max_ops between phases, and checks each
// result against fixed expectations or an in-bench enumeration of the search.
`default_nettype none
module tb;
  localparam int unsigned REG_MAX_OPS = 0;
  localparam int unsigned WATCHDOG_LIMIT = 300000;
  localparam int unsigned SETTLE_CYCLES = 8;

  typedef enum logic {ROW_CFG, ROW_CMD} row_kind_e;

  typedef struct {
    row_kind_e   kind;
    logic [2:0]  addr;
    logic [3:0]  value;
    logic        op;
    logic [15:0] tt;
    bit          fixed;
    logic [3:0]  len;
    logic [59:0] prog;
    logic [16:0] fill;
  } stim_row_t;

  typedef struct {
    logic [3:0]  len;
    logic [59:0] prog;
    logic [16:0] fill;
  } entry_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        start = 1'b0;
  logic        busy;
  logic        opcode_i = sbps_pkg::CMD_READ;
  logic [15:0] truth_table_i = '0;
  logic        result_valid_o;
  logic [3:0]  entry_length_o;
  logic [59:0] entry_program_o;
  logic [16:0] filled_count_o;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;

  shortest_bitwise_program_search_unit DUT (
    .clk_i, .rst_ni, .start, .busy, .opcode_i, .truth_table_i,
    .result_valid_o, .entry_length_o, .entry_program_o, .filled_count_o,
    .psel, .penable, .pwrite, .paddr, .pwdata, .prdata, .pready
  );

  always #4 clk_i = ~clk_i;

  // Predictor state: the program table, its fill count and the register.
  logic [63:0] prog_table [65536];
  logic [16:0] tables_with_prog;
  logic [3:0]  max_ops_q;
  logic [15:0] known_tables [$];

  entry_t      pending_entries [$];
  int unsigned errors = 0;
  int unsigned commands_sent = 0;
  int unsigned runs_sent = 0;
  int unsigned results_seen = 0;
  int unsigned idle_cycles = 0;
  bit          cmd_taken;

  // Walk the whole depth-first enumeration, pruned as the block prunes it.
  task automatic run_enumeration();
    int unsigned levels, lvl, op, prev_op, s, ns, remaining, a, t, elen, i;
    int unsigned fops [15];
    int unsigned fcnt [15];
    logic [15:0] fvals [15][4];
    logic [59:0] prog;
    bit          descend;
    levels = max_ops_q;
    if (levels < 1) levels = 1;
    if (levels > sbps_pkg::MaxLenDef) levels = sbps_pkg::MaxLenDef;
    foreach (prog_table[k]) prog_table[k] = '0;
    tables_with_prog = '0;
    fops[0] = 0;
    fcnt[0] = 0;
    lvl = 0;
    descend = 1'b1;
    while (1) begin
      if (descend && lvl + 1 < levels) begin
        lvl++;
        fops[lvl] = sbps_pkg::OP_PUSH1;
      end else begin
        if (lvl == 0) break;
        fops[lvl]++;
        if (fops[lvl] > sbps_pkg::OP_NOT) begin
          lvl--;
          descend = 1'b0;
          if (lvl == 0) break;
          continue;
        end
      end
      descend = 1'b0;
      op = fops[lvl];
      prev_op = fops[lvl-1];
      s = fcnt[lvl-1];
      if (s >= sbps_pkg::MaxStackDef) continue;
      // Skip the mirrored operand order of commutative ops.
      if (lvl >= 2 && fops[lvl-2] >= sbps_pkg::OP_PUSH1 && prev_op <= sbps_pkg::OP_PUSH4) begin
        a = fops[lvl-2];
        if ((op == sbps_pkg::OP_AND || op == sbps_pkg::OP_OR) && a >= prev_op) continue;
        if (op == sbps_pkg::OP_XOR && a > prev_op) continue;
      end
      if (op >= sbps_pkg::OP_AND && op <= sbps_pkg::OP_XOR && s < 2) continue;
      if (op == sbps_pkg::OP_NOT && s == 0) continue;
      if (op <= sbps_pkg::OP_PUSH4) ns = s + 1;
      else if (op == sbps_pkg::OP_NOT) ns = s;
      else ns = s - 1;
      remaining = levels - 1 - lvl;
      if (ns - 1 > remaining) continue;
      if (prev_op == sbps_pkg::OP_NOT && op == sbps_pkg::OP_NOT) continue;
      for (i = 0; i < s; i++) fvals[lvl][i] = fvals[lvl-1][i];
      if (op <= sbps_pkg::OP_PUSH4)
        fvals[lvl][s] = sbps_pkg::var_pattern(4'(op));
      else if (op == sbps_pkg::OP_NOT)
        fvals[lvl][s-1] = ~fvals[lvl][s-1];
      else if (op == sbps_pkg::OP_AND)
        fvals[lvl][s-2] = fvals[lvl][s-2] & fvals[lvl][s-1];
      else if (op == sbps_pkg::OP_OR)
        fvals[lvl][s-2] = fvals[lvl][s-2] | fvals[lvl][s-1];
      else
        fvals[lvl][s-2] = fvals[lvl][s-2] ^ fvals[lvl][s-1];
      fcnt[lvl] = ns;
      if (ns == 1) begin
        t = fvals[lvl][0];
        elen = prog_table[t][63:60];
        // Drop the branch when an equal or shorter program already owns it.
        if (elen != 0 && elen <= lvl) continue;
        if (elen == 0) tables_with_prog++;
        prog = '0;
        for (i = 1; i <= lvl; i++) prog |= 60'(fops[i] & 15) << (4 * (i - 1));
        prog_table[t] = {4'(lvl), prog};
      end
      descend = 1'b1;
    end
    known_tables.delete();
    foreach (prog_table[k])
      if (prog_table[k][63:60] != 0) known_tables.insert(known_tables.size(), 16'(k));
  endtask

  function automatic entry_t lookup_entry(logic [15:0] tt);
    entry_t e;
    e.len = prog_table[tt][63:60];
    e.prog = prog_table[tt][59:0];
    e.fill = tables_with_prog;
    return e;
  endfunction

  // Hand one command over; the transfer happens at the edge where busy is low.
  task automatic send_command(logic op, logic [15:0] tt, bit fixed, entry_t fixed_e);
    entry_t e;
    @(negedge clk_i);
    start <= 1'b1;
    opcode_i <= op;
    truth_table_i <= tt;
    do @(posedge clk_i); while (busy);
    if (op == sbps_pkg::CMD_RUN) begin
      run_enumeration();
      e.len = '0;
      e.prog = '0;
      e.fill = tables_with_prog;
      runs_sent++;
    end else begin
      e = lookup_entry(tt);
    end
    pending_entries.insert(pending_entries.size(), fixed ? fixed_e : e);
    commands_sent++;
  endtask

  task automatic hold_off(int unsigned pct);
    if ($urandom_range(99) < pct) begin
      @(negedge clk_i);
      start <= 1'b0;
      repeat ($urandom_range(4)) @(negedge clk_i);
    end
  endtask

  // Wait for every outstanding result, then let the block settle.
  task automatic drain();
    @(negedge clk_i);
    start <= 1'b0;
    while (pending_entries.size() != 0) @(negedge clk_i);
    repeat (SETTLE_CYCLES) @(negedge clk_i);
    while (busy) @(negedge clk_i);
  endtask

  task automatic write_reg(logic [2:0] addr, logic [3:0] value);
    drain();
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= addr;
    pwdata <= 32'(value);
    @(negedge clk_i);
    penable <= 1'b1;
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    if (addr == 3'(4 * REG_MAX_OPS)) max_ops_q = value;
    // Read the register back over the same port.
    @(negedge clk_i);
    psel <= 1'b1;
    paddr <= 3'(4 * REG_MAX_OPS);
    @(negedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    if (prdata !== 32'(max_ops_q))
      $error("max_ops: expected %0d, got %0d", max_ops_q, prdata);
    @(negedge clk_i);
    psel <= 1'b0;
    penable <= 1'b0;
  endtask

  // Compare each result transfer with the oldest expectation.
  always @(posedge clk_i) begin
    if (rst_ni && result_valid_o) begin
      results_seen++;
      if (pending_entries.size() == 0) begin
        $error("result with no command waiting");
        errors++;
      end else begin
        entry_t e;
        e = pending_entries.pop_front();
        if (entry_length_o !== e.len) begin
          $error("entry_length: expected %0d, got %0d", e.len, entry_length_o);
          errors++;
        end
        if (entry_program_o !== e.prog) begin
          $error("entry_program: expected %h, got %h", e.prog, entry_program_o);
          errors++;
        end
        if (filled_count_o !== e.fill) begin
          $error("filled_count: expected %0d, got %0d", e.fill, filled_count_o);
          errors++;
        end
      end
    end
  end

  // Watchdog: count cycles in which no transfer happens in either direction.
  always @(posedge clk_i) begin
    cmd_taken = start && !busy;
    if (!rst_ni || cmd_taken || result_valid_o) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("tb failed");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  stim_row_t rows [$];

  function automatic stim_row_t cfg_row(logic [2:0] addr, logic [3:0] value);
    stim_row_t r;
    r.kind = ROW_CFG;
    r.addr = addr;
    r.value = value;
    r.op = sbps_pkg::CMD_READ;
    r.tt = '0;
    r.fixed = 1'b0;
    r.len = '0;
    r.prog = '0;
    r.fill = '0;
    return r;
  endfunction

  function automatic stim_row_t cmd_row(logic op, logic [15:0] tt, bit fixed,
                                        logic [3:0] len, logic [59:0] prog,
                                        logic [16:0] fill);
    stim_row_t r;
    r.kind = ROW_CMD;
    r.addr = '0;
    r.value = '0;
    r.op = op;
    r.tt = tt;
    r.fixed = fixed;
    r.len = len;
    r.prog = prog;
    r.fill = fill;
    return r;
  endfunction

  initial begin
    int unsigned idle_pct [3];
    logic [3:0]  phase_ops [3];
    logic [15:0] tt;
    entry_t      fe;
    idle_pct = '{24, 53, 0};
    phase_ops = '{4'd5, 4'd3, 4'd4};
    foreach (prog_table[k]) prog_table[k] = '0;
    tables_with_prog = '0;
    max_ops_q = 4'd15;

    // Directed rows: empty table after reset, the max_ops extremes, single ops.
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h0000, 1'b1, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'hFFFF, 1'b1, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cfg_row(3'(4 * REG_MAX_OPS), 4'd15)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h1234, 1'b1, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cfg_row(3'(4 * REG_MAX_OPS), 4'd1)};
    rows = {rows, cmd_row(sbps_pkg::CMD_RUN, 16'hFFFF, 1'b1, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cfg_row(3'(4 * REG_MAX_OPS), 4'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_RUN, 16'h0000, 1'b1, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'hAAAA, 1'b1, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cfg_row(3'(4 * REG_MAX_OPS), 4'd2)};
    rows = {rows, cfg_row(3'd4, 4'd9)};
    rows = {rows, cmd_row(sbps_pkg::CMD_RUN, 16'h5A5A, 1'b1, 4'd0, 60'd0, 17'd4)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'hAAAA, 1'b1, 4'd1, 60'h1, 17'd4)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'hFF00, 1'b1, 4'd1, 60'h4, 17'd4)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h5555, 1'b1, 4'd0, 60'd0, 17'd4)};
    rows = {rows, cfg_row(3'(4 * REG_MAX_OPS), 4'd3)};
    rows = {rows, cmd_row(sbps_pkg::CMD_RUN, 16'h0000, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h5555, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h0000, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'hF0F0, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'hFFFF, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cfg_row(3'(4 * REG_MAX_OPS), 4'd4)};
    rows = {rows, cmd_row(sbps_pkg::CMD_RUN, 16'hFFFF, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h8888, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h6666, 1'b0, 4'd0, 60'd0, 17'd0)};
    rows = {rows, cmd_row(sbps_pkg::CMD_READ, 16'h0000, 1'b0, 4'd0, 60'd0, 17'd0)};

    repeat (6) @(negedge clk_i);
    rst_ni <= 1'b1;

    foreach (rows[i]) begin
      if (rows[i].kind == ROW_CFG) begin
        write_reg(rows[i].addr, rows[i].value);
      end else begin
        fe.len = rows[i].len;
        fe.prog = rows[i].prog;
        fe.fill = rows[i].fill;
        send_command(rows[i].op, rows[i].tt, rows[i].fixed, fe);
      end
    end

    // Random part: one fresh search per phase, then reads, half of them aimed
    // at tables that hold a program so the lengths and programs get exercised.
    for (int p = 0; p < 3; p++) begin
      write_reg(3'(4 * REG_MAX_OPS), phase_ops[p]);
      send_command(sbps_pkg::CMD_RUN, 16'($urandom), 1'b0, fe);
      for (int n = 0; n < 465; n++) begin
        hold_off(idle_pct[p]);
        if (known_tables.size() != 0 && $urandom_range(1))
          tt = known_tables[$urandom_range(known_tables.size() - 1)];
        else
          tt = 16'($urandom_range(65535));
        send_command(sbps_pkg::CMD_READ, tt, 1'b0, fe);
      end
    end

    drain();
    $display("covered %0d commands (%0d searches), checked %0d results",
             commands_sent, runs_sent, results_seen);
    $display("max_ops taken through 0, 1, 2, 3, 4, 5 and 15, plus an unmapped write");
    if (errors == 0) begin
      $display("tb passed");
    end else begin
      $display("tb failed");
    end
    $finish;
  end
endmodule
`default_nettype wire
